FILE: hdl/scot_pkg.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test: shared package
// Region codes for the nearest feature of the capsule segment.
// ----------------------------------------------------------------------------
package scot_pkg;

  // Nearest feature of the segment to the sphere center.
  typedef enum logic [1:0] {
    REGION_START = 2'd0,
    REGION_END   = 2'd1,
    REGION_INNER = 2'd2
  } region_t;

  // Width of the squared distance result field.
  localparam int DIST_OUT_BITS = 34;

  // Width of the radius fields and of the squared radius sum.
  localparam int RADIUS_BITS = 15;
  localparam int RSQ_BITS    = 2 * (RADIUS_BITS + 1);

endpackage

FILE: hdl/scot_front.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test: geometry front end
// Four register stages: differences, products, dot-product sums, region select.
// ----------------------------------------------------------------------------
module scot_front #(
  parameter int COORD_BITS = 16,
  parameter int W          = 2 * COORD_BITS + 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [COORD_BITS-1:0]     cx,
  input  logic signed [COORD_BITS-1:0]     cy,
  input  logic signed [COORD_BITS-1:0]     cz,
  input  logic [scot_pkg::RADIUS_BITS-1:0] rs,
  input  logic signed [COORD_BITS-1:0]     sx,
  input  logic signed [COORD_BITS-1:0]     sy,
  input  logic signed [COORD_BITS-1:0]     sz,
  input  logic signed [COORD_BITS-1:0]     ex,
  input  logic signed [COORD_BITS-1:0]     ey,
  input  logic signed [COORD_BITS-1:0]     ez,
  input  logic [scot_pkg::RADIUS_BITS-1:0] rc,
  output logic                             out_vld,
  output logic [W-1:0]                     div_e,
  output logic [W-1:0]                     div_f,
  output scot_pkg::region_t                region,
  output logic [W-1:0]                     acac,
  output logic [W-1:0]                     near_dist,
  output logic [scot_pkg::RSQ_BITS-1:0]    rsq
);

  localparam int D_W  = COORD_BITS + 1;
  localparam int P_W  = 2 * D_W;
  localparam int E_W  = W + 1;
  localparam int RS_W = scot_pkg::RADIUS_BITS + 1;

  // Stage 1: coordinate differences and radius sum.
  logic                  v1_r;
  logic signed [D_W-1:0] abx_r, aby_r, abz_r, acx_r, acy_r, acz_r, bcx_r, bcy_r, bcz_r;
  logic [RS_W-1:0]       rsum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
    abx_r  <= D_W'(ex) - D_W'(sx);
    aby_r  <= D_W'(ey) - D_W'(sy);
    abz_r  <= D_W'(ez) - D_W'(sz);
    acx_r  <= D_W'(cx) - D_W'(sx);
    acy_r  <= D_W'(cy) - D_W'(sy);
    acz_r  <= D_W'(cz) - D_W'(sz);
    bcx_r  <= D_W'(cx) - D_W'(ex);
    bcy_r  <= D_W'(cy) - D_W'(ey);
    bcz_r  <= D_W'(cz) - D_W'(ez);
    rsum_r <= RS_W'(rs) + RS_W'(rc);
  end

  // Stage 2: one multiplier per product term.
  logic                  v2_r;
  logic signed [P_W-1:0] pe_r [0:2];
  logic signed [P_W-1:0] pf_r [0:2];
  logic signed [P_W-1:0] pa_r [0:2];
  logic signed [P_W-1:0] pb_r [0:2];
  logic [scot_pkg::RSQ_BITS-1:0] rsq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pe_r[0] <= acx_r * abx_r;
    pe_r[1] <= acy_r * aby_r;
    pe_r[2] <= acz_r * abz_r;
    pf_r[0] <= abx_r * abx_r;
    pf_r[1] <= aby_r * aby_r;
    pf_r[2] <= abz_r * abz_r;
    pa_r[0] <= acx_r * acx_r;
    pa_r[1] <= acy_r * acy_r;
    pa_r[2] <= acz_r * acz_r;
    pb_r[0] <= bcx_r * bcx_r;
    pb_r[1] <= bcy_r * bcy_r;
    pb_r[2] <= bcz_r * bcz_r;
    rsq2_r  <= scot_pkg::RSQ_BITS'(rsum_r) * scot_pkg::RSQ_BITS'(rsum_r);
  end

  // Stage 3: dot-product sums. Squares are non-negative and fit W bits.
  logic                  v3_r;
  logic signed [E_W-1:0] e_r;
  logic [W-1:0]          f_r, acac3_r, bcbc3_r;
  logic [scot_pkg::RSQ_BITS-1:0] rsq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    e_r     <= E_W'(pe_r[0]) + E_W'(pe_r[1]) + E_W'(pe_r[2]);
    f_r     <= W'(unsigned'(pf_r[0])) + W'(unsigned'(pf_r[1])) + W'(unsigned'(pf_r[2]));
    acac3_r <= W'(unsigned'(pa_r[0])) + W'(unsigned'(pa_r[1])) + W'(unsigned'(pa_r[2]));
    bcbc3_r <= W'(unsigned'(pb_r[0])) + W'(unsigned'(pb_r[1])) + W'(unsigned'(pb_r[2]));
    rsq3_r  <= rsq2_r;
  end

  // Stage 4: pick the nearest feature. A degenerate segment gives e of zero.
  logic              e_le0, e_ge_f;
  scot_pkg::region_t region_nxt;
  logic              v4_r;
  logic [W-1:0]      e4_r, f4_r, acac4_r, near4_r;
  scot_pkg::region_t region_r;
  logic [scot_pkg::RSQ_BITS-1:0] rsq4_r;

  assign e_le0  = e_r[E_W-1] || (e_r == '0);
  assign e_ge_f = (e_r[W-1:0] >= f_r);

  always_comb begin
    priority if (e_le0) begin
      region_nxt = scot_pkg::REGION_START;
    end else if (e_ge_f) begin
      region_nxt = scot_pkg::REGION_END;
    end else begin
      region_nxt = scot_pkg::REGION_INNER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    e4_r     <= e_r[W-1:0];
    f4_r     <= f_r;
    acac4_r  <= acac3_r;
    near4_r  <= (region_nxt == scot_pkg::REGION_END) ? bcbc3_r : acac3_r;
    region_r <= region_nxt;
    rsq4_r   <= rsq3_r;
  end

  assign out_vld   = v4_r;
  assign div_e     = e4_r;
  assign div_f     = f4_r;
  assign region    = region_r;
  assign acac      = acac4_r;
  assign near_dist = near4_r;
  assign rsq       = rsq4_r;

endmodule

FILE: hdl/scot_muldiv.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test: pipelined multiply-divide
// Computes floor(e*e / f) for e < f, one bit of e per stage, MSB first.
// ----------------------------------------------------------------------------
module scot_muldiv #(
  parameter int W      = 34,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [W-1:0]      e,
  input  logic [W-1:0]      f,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [W-1:0]      quo,
  output logic [SIDE_W-1:0] side_out
);

  // Each stage keeps remainder r < f and quotient q = floor(e*prefix / f).
  // Adding e to 2r stays below 3f, so at most 2f is taken off per stage.
  localparam int R_W = W + 2;

  logic              vld_r  [0:W-1];
  logic [R_W-1:0]    rem_r  [0:W-1];
  logic [W-1:0]      quo_r  [0:W-1];
  logic [W-1:0]      e_r    [0:W-1];
  logic [W-1:0]      f_r    [0:W-1];
  logic [SIDE_W-1:0] side_r [0:W-1];

  logic              vld_src  [0:W-1];
  logic [R_W-1:0]    rem_src  [0:W-1];
  logic [W-1:0]      quo_src  [0:W-1];
  logic [W-1:0]      e_src    [0:W-1];
  logic [W-1:0]      f_src    [0:W-1];
  logic [SIDE_W-1:0] side_src [0:W-1];

  for (genvar g = 0; g < W; g++) begin : g_stage
    logic [R_W-1:0] sum, f1, f2, rem_nxt;
    logic [W-1:0]   quo_nxt;

    // Stage input comes from the ports or from the previous stage.
    if (g == 0) begin : g_first
      assign vld_src[g]  = in_vld;
      assign rem_src[g]  = '0;
      assign quo_src[g]  = '0;
      assign e_src[g]    = e;
      assign f_src[g]    = f;
      assign side_src[g] = side_in;
    end else begin : g_next
      assign vld_src[g]  = vld_r[g-1];
      assign rem_src[g]  = rem_r[g-1];
      assign quo_src[g]  = quo_r[g-1];
      assign e_src[g]    = e_r[g-1];
      assign f_src[g]    = f_r[g-1];
      assign side_src[g] = side_r[g-1];
    end

    // Shift in the next multiplier bit and reduce.
    always_comb begin
      sum = {rem_src[g][R_W-2:0], 1'b0}
            + (e_src[g][W-1-g] ? R_W'(e_src[g]) : R_W'(0));
      f1  = R_W'(f_src[g]);
      f2  = {1'b0, f_src[g], 1'b0};
      priority if (sum >= f2) begin
        rem_nxt = sum - f2;
        quo_nxt = {quo_src[g][W-2:0], 1'b0} + W'(2);
      end else if (sum >= f1) begin
        rem_nxt = sum - f1;
        quo_nxt = {quo_src[g][W-2:0], 1'b0} + W'(1);
      end else begin
        rem_nxt = sum;
        quo_nxt = {quo_src[g][W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_src[g];
      end
      rem_r[g]  <= rem_nxt;
      quo_r[g]  <= quo_nxt;
      e_r[g]    <= e_src[g];
      f_r[g]    <= f_src[g];
      side_r[g] <= side_src[g];
    end
  end

  assign out_vld  = vld_r[W-1];
  assign quo      = quo_r[W-1];
  assign side_out = side_r[W-1];

endmodule

FILE: hdl/sphere_capsule_overlap_test_top.sv
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test: top level
// Squared distance from a sphere center to a capsule segment, and hit flag.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle: busy is always low, so an
// item is accepted whenever start is high. Each item gives exactly one result,
// shown for one cycle with out_valid high. The item passes through the front
// end, the multiply-divide pipeline, which retires one bit of the projection
// per stage, and the output register. Results come out in item order and
// cannot be held off.
module sphere_capsule_overlap_test_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_BITS-1:0]     in_center_x,
  input  logic signed [COORD_BITS-1:0]     in_center_y,
  input  logic signed [COORD_BITS-1:0]     in_center_z,
  input  logic [scot_pkg::RADIUS_BITS-1:0] in_sphere_radius,
  input  logic signed [COORD_BITS-1:0]     in_seg_start_x,
  input  logic signed [COORD_BITS-1:0]     in_seg_start_y,
  input  logic signed [COORD_BITS-1:0]     in_seg_start_z,
  input  logic signed [COORD_BITS-1:0]     in_seg_end_x,
  input  logic signed [COORD_BITS-1:0]     in_seg_end_y,
  input  logic signed [COORD_BITS-1:0]     in_seg_end_z,
  input  logic [scot_pkg::RADIUS_BITS-1:0] in_capsule_radius,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [scot_pkg::DIST_OUT_BITS-1:0] out_dist_sq,
  output logic [1:0]                       out_nearest_region
);

  localparam int W      = 2 * COORD_BITS + 2;
  localparam int SIDE_W = 2 + 2 * W + scot_pkg::RSQ_BITS;
  localparam int CMP_W  = (W > scot_pkg::RSQ_BITS) ? W : scot_pkg::RSQ_BITS;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Front end: differences, products, sums and region.
  logic                          fe_vld;
  logic [W-1:0]                  fe_e, fe_f, fe_acac, fe_near;
  scot_pkg::region_t             fe_region;
  logic [scot_pkg::RSQ_BITS-1:0] fe_rsq;

  scot_front #(
    .COORD_BITS (COORD_BITS),
    .W          (W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start),
    .cx        (in_center_x),
    .cy        (in_center_y),
    .cz        (in_center_z),
    .rs        (in_sphere_radius),
    .sx        (in_seg_start_x),
    .sy        (in_seg_start_y),
    .sz        (in_seg_start_z),
    .ex        (in_seg_end_x),
    .ey        (in_seg_end_y),
    .ez        (in_seg_end_z),
    .rc        (in_capsule_radius),
    .out_vld   (fe_vld),
    .div_e     (fe_e),
    .div_f     (fe_f),
    .region    (fe_region),
    .acac      (fe_acac),
    .near_dist (fe_near),
    .rsq       (fe_rsq)
  );

  // Projection term; other item data rides alongside.
  logic              md_vld;
  logic [W-1:0]      md_quo;
  logic [SIDE_W-1:0] md_side;

  scot_muldiv #(
    .W      (W),
    .SIDE_W (SIDE_W)
  ) u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fe_vld),
    .e        (fe_e),
    .f        (fe_f),
    .side_in  ({fe_region, fe_acac, fe_near, fe_rsq}),
    .out_vld  (md_vld),
    .quo      (md_quo),
    .side_out (md_side)
  );

  // Final distance and radius compare.
  logic [1:0]                    md_region_bits;
  scot_pkg::region_t             md_region;
  logic [W-1:0]                  md_acac, md_near, dist_val;
  logic [scot_pkg::RSQ_BITS-1:0] md_rsq;
  logic                          hit_nxt;

  assign {md_region_bits, md_acac, md_near, md_rsq} = md_side;
  assign md_region = scot_pkg::region_t'(md_region_bits);
  assign dist_val  = (md_region == scot_pkg::REGION_INNER) ? (md_acac - md_quo) : md_near;
  assign hit_nxt   = (CMP_W'(dist_val) <= CMP_W'(md_rsq));

  logic                              valid_r, hit_r;
  logic [W-1:0]                      dist_r;
  scot_pkg::region_t                 region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= md_vld;
    end
    hit_r    <= hit_nxt;
    dist_r   <= dist_val;
    region_r <= md_region;
  end

  // Result field holds the low bits of the distance.
  if (W >= scot_pkg::DIST_OUT_BITS) begin : g_trunc
    assign out_dist_sq = dist_r[scot_pkg::DIST_OUT_BITS-1:0];
  end else begin : g_ext
    assign out_dist_sq = scot_pkg::DIST_OUT_BITS'(dist_r);
  end

  assign out_valid          = valid_r;
  assign out_hit            = hit_r;
  assign out_nearest_region = region_r;

endmodule

FILE: bench/sphere_capsule_overlap_test_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sphere-capsule overlap test: testbench
// Drives a table of directed geometry queries, then random ones. Each result
// is compared with a prediction made from exact wide integer arithmetic, or with an answer typed into the table.
// ----------------------------------------------------------------------------
module sphere_capsule_overlap_test_top_test;

  localparam int CB         = 16;
  localparam int LATENCY    = 2 * CB + 7;
  localparam int NUM_RANDOM = 1530;
  localparam longint CYCLE_LIMIT = 200000;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [scot_pkg::RADIUS_BITS-1:0] radius_t;

  // One geometry query.
  typedef struct {
    coord_t  cx, cy, cz;
    radius_t rs;
    coord_t  sx, sy, sz;
    coord_t  ex, ey, ez;
    radius_t rc;
  } query_t;

  // One overlap answer.
  typedef struct {
    logic                               hit;
    logic [scot_pkg::DIST_OUT_BITS-1:0] dist_sq;
    scot_pkg::region_t                  region;
  } answer_t;

  // Directed row: query, plus an answer typed in where it is obvious.
  typedef struct {
    query_t  q;
    logic    known;
    answer_t a;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t  in_center_x = '0, in_center_y = '0, in_center_z = '0;
  radius_t in_sphere_radius = '0;
  coord_t  in_seg_start_x = '0, in_seg_start_y = '0, in_seg_start_z = '0;
  coord_t  in_seg_end_x = '0, in_seg_end_y = '0, in_seg_end_z = '0;
  radius_t in_capsule_radius = '0;
  logic out_valid;
  logic out_hit;
  logic [scot_pkg::DIST_OUT_BITS-1:0] out_dist_sq;
  logic [1:0] out_nearest_region;

  answer_t pending_answers[$];
  int      error_count = 0;
  longint  cycle_count = 0;

  sphere_capsule_overlap_test_top #(.COORD_BITS(CB)) dut (.*);

  always #2 clk = ~clk;

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Exact squared distance from center to segment and hit flag.
  function automatic answer_t overlap_answer(query_t q);
    longint abx, aby, abz, acx, acy, acz, bcx, bcy, bcz, e, f, acac, rsum;
    logic [127:0] ee;
    logic [127:0] dist_val;
    answer_t a;
    abx = longint'(q.ex) - longint'(q.sx);
    aby = longint'(q.ey) - longint'(q.sy);
    abz = longint'(q.ez) - longint'(q.sz);
    acx = longint'(q.cx) - longint'(q.sx);
    acy = longint'(q.cy) - longint'(q.sy);
    acz = longint'(q.cz) - longint'(q.sz);
    bcx = longint'(q.cx) - longint'(q.ex);
    bcy = longint'(q.cy) - longint'(q.ey);
    bcz = longint'(q.cz) - longint'(q.ez);
    e = acx * abx + acy * aby + acz * abz;
    f = abx * abx + aby * aby + abz * abz;
    acac = acx * acx + acy * acy + acz * acz;
    if (e <= 0) begin
      dist_val = 128'(acac);
      a.region = scot_pkg::REGION_START;
    end else if (e >= f) begin
      dist_val = 128'(bcx * bcx + bcy * bcy + bcz * bcz);
      a.region = scot_pkg::REGION_END;
    end else begin
      ee = 128'(e) * 128'(e);
      dist_val = 128'(acac) - ee / 128'(f);
      a.region = scot_pkg::REGION_INNER;
    end
    rsum = longint'(q.rs) + longint'(q.rc);
    a.hit = (dist_val <= 128'(rsum * rsum));
    a.dist_sq = dist_val[scot_pkg::DIST_OUT_BITS-1:0];
    return a;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      1: return coord_t'($urandom_range(0, 200)) - coord_t'(100);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic radius_t rand_radius();
    case ($urandom_range(0, 4))
      0: return radius_t'($urandom_range(0, 1) ? 15'h7fff : 15'h0);
      default: return radius_t'($urandom);
    endcase
  endfunction

  // Random query: random coordinates and radii, with a degenerate segment one time in ten.
  function automatic query_t rand_query();
    query_t q;
    q.cx = rand_coord(); q.cy = rand_coord(); q.cz = rand_coord();
    q.sx = rand_coord(); q.sy = rand_coord(); q.sz = rand_coord();
    q.ex = rand_coord(); q.ey = rand_coord(); q.ez = rand_coord();
    if ($urandom_range(0, 9) == 0) begin
      q.ex = q.sx; q.ey = q.sy; q.ez = q.sz;
    end
    q.rs = rand_radius();
    q.rc = rand_radius();
    return q;
  endfunction

  // Present one query and hold it until it is taken.
  task automatic send_query(query_t q);
    start <= 1'b1;
    in_center_x <= q.cx; in_center_y <= q.cy; in_center_z <= q.cz;
    in_sphere_radius <= q.rs;
    in_seg_start_x <= q.sx; in_seg_start_y <= q.sy; in_seg_start_z <= q.sz;
    in_seg_end_x <= q.ex; in_seg_end_y <= q.ey; in_seg_end_z <= q.ez;
    in_capsule_radius <= q.rc;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Result checking against the oldest pending answer.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: dist_sq %0d", out_dist_sq);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, out_hit);
          error_count++;
        end
        if (out_dist_sq !== want.dist_sq) begin
          $error("dist_sq: expected %0d, actual %0d", want.dist_sq, out_dist_sq);
          error_count++;
        end
        if (out_nearest_region !== want.region) begin
          $error("nearest_region: expected %0d, actual %0d", want.region,
                 out_nearest_region);
          error_count++;
        end
      end
    end
  end

  initial begin
    row_t    rows[$];
    row_t    r;
    query_t  q;
    answer_t a;
    int      calm_lo;
    int      pause_at;

    // Degenerate segment at origin, zero radii: touching, start region.
    r.q = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}; r.known = 1;
    r.a = '{1'b1, 34'd0, scot_pkg::REGION_START}; rows.push_back(r);
    // Degenerate segment, distance 5 from 3-4-0 with radii 2+3: hit.
    r.q = '{3, 4, 0, 2, 0, 0, 0, 0, 0, 0, 3}; r.known = 1;
    r.a = '{1'b1, 34'd25, scot_pkg::REGION_START}; rows.push_back(r);
    // Same with radii 2+2: miss.
    r.q = '{3, 4, 0, 2, 0, 0, 0, 0, 0, 0, 2}; r.known = 1;
    r.a = '{1'b0, 34'd25, scot_pkg::REGION_START}; rows.push_back(r);
    // Projection exactly at start.
    r.q = '{0, 5, 0, 0, 0, 0, 0, 10, 0, 0, 0}; r.known = 1;
    r.a = '{1'b0, 34'd25, scot_pkg::REGION_START}; rows.push_back(r);
    // Projection exactly at end.
    r.q = '{10, 5, 0, 0, 0, 0, 0, 10, 0, 0, 0}; r.known = 1;
    r.a = '{1'b0, 34'd25, scot_pkg::REGION_END}; rows.push_back(r);
    // Interior, exact.
    r.q = '{5, 5, 0, 5, 0, 0, 0, 10, 0, 0, 0}; r.known = 1;
    r.a = '{1'b1, 34'd25, scot_pkg::REGION_INNER}; rows.push_back(r);
    // Interior with floor division.
    r.q = '{1, 1, 1, 0, 0, 0, 0, 3, 1, 0, 0}; r.known = 0; rows.push_back(r);
    // Past the end.
    r.q = '{-50, 7, 3, 9, 0, 0, 0, -20, 0, 0, 1}; r.known = 0; rows.push_back(r);
    // Before the start.
    r.q = '{50, -7, 3, 9, 0, 0, 0, -20, 0, 0, 1}; r.known = 0; rows.push_back(r);
    // Extreme corners: largest distance, with largest and with zero radii.
    r.q = '{32767, 32767, 32767, 15'h7fff, -32768, -32768, -32768,
            -32768, -32768, -32768, 15'h7fff}; r.known = 0; rows.push_back(r);
    r.q = '{-32768, -32768, -32768, 0, 32767, 32767, 32767,
            32767, 32767, 32767, 0}; r.known = 0; rows.push_back(r);
    // Longest segment, center in the middle.
    r.q = '{0, 0, 0, 15'h7fff, -32768, -32768, -32768,
            32767, 32767, 32767, 15'h7fff}; r.known = 0; rows.push_back(r);
    r.q = '{32767, -32768, 0, 100, -32768, 32767, -32768,
            32767, -32768, 32767, 200}; r.known = 0; rows.push_back(r);
    r.q = '{-1, -1, -1, 15'h5555, 1, -1, 1, -1, 1, -1, 15'h2aaa};
    r.known = 0; rows.push_back(r);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (rows[i]) begin
      a = overlap_answer(rows[i].q);
      if (rows[i].known)
        a = rows[i].a;
      pending_answers.push_back(a);
      send_query(rows[i].q);
      if ($urandom_range(0, 3) == 0)
        idle_cycle();
    end

    // Random part, with a calm stretch and one full drain in between.
    calm_lo = $urandom_range(200, 500);
    pause_at = 900;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == pause_at) begin
        start <= 1'b0;
        while (pending_answers.size() != 0)
          @(posedge clk);
      end
      if (!(n >= calm_lo && n < calm_lo + 300))
        while ($urandom_range(0, 99) < 16)
          idle_cycle();
      q = rand_query();
      pending_answers.push_back(overlap_answer(q));
      send_query(q);
    end
    start <= 1'b0;

    while (pending_answers.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
